### rtl/adv_data_type_finder_top_macros.svh
// Assertion macros shared by the advertising data type finder RTL.
`ifndef ADV_DATA_TYPE_FINDER_TOP_MACROS_SVH
`define ADV_DATA_TYPE_FINDER_TOP_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define ADT_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define ADT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/adt_pkg.sv
// Types and constants of the advertising data type finder.
package adt_pkg;

   localparam int BYTE_W   = 8;
   localparam int OFFSET_W = 6;
   localparam int LENGTH_W = 8;
   localparam int SUM_W    = 9;

   localparam logic [BYTE_W-1:0] TYPE_MIN     = 8'h01;
   localparam logic [BYTE_W-1:0] TYPE_MAX     = 8'h21;
   localparam logic [BYTE_W-1:0] TYPE_ANY     = 8'hFF;
   localparam logic [BYTE_W-1:0] WANTED_RESET = 8'h09;

   // Register index of wanted_type, decoded from paddr[2].
   localparam logic CSR_WANTED_IDX = 1'b0;

   typedef enum logic [1:0] {
      PH_DONE   = 2'd0,
      PH_LENGTH = 2'd1,
      PH_TYPE   = 2'd2,
      PH_SKIP   = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      ST_FOUND     = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_INVALID   = 2'd2
   } status_type;

   typedef struct packed {
      logic                hit;
      status_type          status;
      logic [OFFSET_W-1:0] value_offset;
      logic [LENGTH_W-1:0] value_length;
   } result_type;

endpackage

### rtl/adt_csr.sv
// APB-style register port holding the wanted advertising data type.
module adt_csr
   import adt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [2:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready,
   output logic [BYTE_W-1:0] wanted_type
);

   logic [BYTE_W-1:0] wanted_ff;
   logic [BYTE_W-1:0] wanted_in;
   logic              wr_en;
   logic              sel_wanted;

   // Registers are word aligned, so only bit 2 picks the register.
   assign sel_wanted = (csr_paddr[2] == CSR_WANTED_IDX);
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;

   always_comb begin
      wanted_in = wanted_ff;
      if (wr_en && sel_wanted) begin
         wanted_in = csr_pwdata[BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wanted_ff <= WANTED_RESET;
      end else begin
         wanted_ff <= wanted_in;
      end
   end

   assign csr_prdata  = sel_wanted ? {24'd0, wanted_ff} : 32'd0;
   assign wanted_type = wanted_ff;

endmodule

### rtl/adt_walker.sv
// Length-type-value walker: parse state and the result of the current byte.
`include "adv_data_type_finder_top_macros.svh"
module adt_walker
   import adt_pkg::*;
#(
   parameter int BUFFER_LIMIT = 62
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic [BYTE_W-1:0] wanted_type,
   input  logic              fire,
   input  logic [BYTE_W-1:0] adv_byte,
   input  logic              start_req,
   output result_type        res
);

   localparam int POS_W = $clog2(BUFFER_LIMIT);
   localparam logic [SUM_W-1:0] LIMIT_SUM = SUM_W'(BUFFER_LIMIT);
   localparam logic [POS_W-1:0] POS_MAX   = POS_W'(BUFFER_LIMIT - 1);

   phase_type         phase_ff, phase_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [BYTE_W-1:0] len_ff, len_in;
   logic [BYTE_W-1:0] skip_ff, skip_in;

   phase_type         eff_phase;
   logic [POS_W-1:0]  eff_pos;
   logic [BYTE_W-1:0] eff_len;
   logic [BYTE_W-1:0] eff_skip;
   logic [SUM_W-1:0]  pos_inc;
   logic [SUM_W-1:0]  pos_len_sum;
   logic [BYTE_W-1:0] len_minus;
   logic [BYTE_W-1:0] skip_minus;
   logic              invalid_cfg;
   logic              length_stop;
   logic              type_hit;
   logic              type_stop;

   // A start drops any parse in progress and, unless the wanted type is invalid, opens on a length byte.
   assign invalid_cfg = ((wanted_type < TYPE_MIN) || (wanted_type > TYPE_MAX)) &&
                        (wanted_type != TYPE_ANY);
   assign eff_phase   = start_req ? PH_LENGTH : phase_ff;
   assign eff_pos     = start_req ? '0 : pos_ff;
   assign eff_len     = start_req ? '0 : len_ff;
   assign eff_skip    = start_req ? '0 : skip_ff;

   assign pos_inc     = SUM_W'(eff_pos) + SUM_W'(1);
   assign pos_len_sum = SUM_W'(eff_pos) + SUM_W'(eff_len);
   assign len_minus   = eff_len - BYTE_W'(1);
   assign skip_minus  = eff_skip - BYTE_W'(1);

   assign length_stop = (adv_byte == '0) || (pos_inc >= LIMIT_SUM);
   assign type_hit    = (adv_byte == wanted_type);
   assign type_stop   = (pos_len_sum >= LIMIT_SUM);

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      len_in   = len_ff;
      skip_in  = skip_ff;
      if (fire) begin
         pos_in  = eff_pos;
         len_in  = eff_len;
         skip_in = eff_skip;
         if (start_req && invalid_cfg) begin
            phase_in = PH_DONE;
         end else begin
            case (eff_phase)
               PH_LENGTH: begin
                  if (length_stop) begin
                     phase_in = PH_DONE;
                  end else begin
                     len_in   = adv_byte;
                     pos_in   = pos_inc[POS_W-1:0];
                     phase_in = PH_TYPE;
                  end
               end
               PH_TYPE: begin
                  if (type_hit || type_stop) begin
                     phase_in = PH_DONE;
                  end else begin
                     skip_in  = len_minus;
                     pos_in   = pos_inc[POS_W-1:0];
                     phase_in = (len_minus != '0) ? PH_SKIP : PH_LENGTH;
                  end
               end
               PH_SKIP: begin
                  skip_in  = skip_minus;
                  pos_in   = pos_inc[POS_W-1:0];
                  phase_in = (skip_minus == '0) ? PH_LENGTH : PH_SKIP;
               end
               default: begin
                  phase_in = PH_DONE;
               end
            endcase
         end
      end
   end

   // Result of the current byte.
   always_comb begin
      res.hit          = 1'b0;
      res.status       = ST_NOT_FOUND;
      res.value_offset = '0;
      res.value_length = '0;
      if (start_req && invalid_cfg) begin
         res.hit    = 1'b1;
         res.status = ST_INVALID;
      end else begin
         case (eff_phase)
            PH_LENGTH: begin
               res.hit = length_stop;
            end
            PH_TYPE: begin
               if (type_hit) begin
                  res.hit          = 1'b1;
                  res.status       = ST_FOUND;
                  res.value_offset = pos_inc[OFFSET_W-1:0];
                  res.value_length = len_minus;
               end else begin
                  res.hit = type_stop;
               end
            end
            default: begin
               res.hit = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_DONE;
         pos_ff   <= '0;
         len_ff   <= '0;
         skip_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         pos_ff   <= pos_in;
         len_ff   <= len_in;
         skip_ff  <= skip_in;
      end
   end

   `ADT_ASSERT_NEXT(a_result_ends_parse, fire && res.hit, phase_ff == PH_DONE,
      "parse continued after a result")
   `ADT_ASSERT_NOW(a_invalid_on_start, fire && res.hit && res.status == ST_INVALID,
      start_req, "invalid_type reported on a byte without start")
   `ADT_ASSERT_NOW(a_skip_nonzero, phase_ff == PH_SKIP, skip_ff != '0,
      "skip phase with nothing left to skip")
   `ADT_ASSERT_NOW(a_pos_bound, phase_ff != PH_DONE, pos_ff <= POS_MAX,
      "byte position ran past the buffer limit")

endmodule

### rtl/adv_data_type_finder_top.sv
// Top level of the advertising data type finder: input and result registers.
//
// The block searches a BLE advertising payload for a wanted AD type.
// Payload words enter on the req_ stream, one byte per word; req_tuser is
// high on the first byte of a payload, which is also its first length byte.
// The wanted type is set through the csr_ port (register 0 at address 0,
// reset value 0x09). The user must write it only while no payload word is
// in flight; the block itself does not enforce this. Per payload at most
// one result word leaves on the rsp_ stream: found with the value offset
// and length, not_found when a zero length byte is seen or the structures
// run to the buffer limit, or invalid_type on the start byte when the
// wanted type is not 0x01..0x21 or 0xFF. Other bytes give no word.
// The byte sits in the input register while the walker decides it, and the
// result register loads the walker's result when it is empty or being
// drained. Throughput is one word per cycle while the result register is
// free, set by the single input register and the single result register
// with the walker between them. When rsp_tready is low, the result holds
// and req_tready stays high until the input register is also occupied. Reset
// empties both registers and leaves the walker waiting for a start byte.
`include "adv_data_type_finder_top_macros.svh"
module adv_data_type_finder_top
   import adt_pkg::*;
#(
   parameter int BUFFER_LIMIT = 62
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] adv_byte
   input  logic        req_tuser,   // [0] start_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [1:0] status, [7:2] value_offset, [15:8] value_length
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [BYTE_W-1:0] wanted_type;
   result_type        res;

   // Input register.
   logic              in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0] in_byte_ff, in_byte_in;
   logic              in_start_ff, in_start_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [OFFSET_W-1:0] rsp_offset_ff, rsp_offset_in;
   logic [LENGTH_W-1:0] rsp_length_ff, rsp_length_in;

   logic req_accept;
   logic out_free;
   logic fire;

   adt_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .wanted_type (wanted_type)
   );

   adt_walker #(
      .BUFFER_LIMIT (BUFFER_LIMIT)
   ) u_walker (
      .clock       (clock),
      .reset       (reset),
      .wanted_type (wanted_type),
      .fire        (fire),
      .adv_byte    (in_byte_ff),
      .start_req   (in_start_ff),
      .res         (res)
   );

   // The result register can take a new word when empty or being drained;
   // the walker steps only then, so a stalled result never gets overwritten.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      in_start_in = in_start_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_tdata;
         in_start_in = req_tuser;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_length_in = rsp_length_ff;
      if (fire) begin
         rsp_valid_in = res.hit;
         if (res.hit) begin
            rsp_status_in = res.status;
            rsp_offset_in = res.value_offset;
            rsp_length_in = res.value_length;
         end
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff    <= in_byte_in;
      in_start_ff   <= in_start_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_length_ff <= rsp_length_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_length_ff, rsp_offset_ff, rsp_status_ff};

   `ADT_ASSERT_NOW(a_miss_fields_zero, rsp_valid_ff && rsp_status_ff != ST_FOUND,
      rsp_offset_ff == '0 && rsp_length_ff == '0,
      "non-found result carries an offset or a length")

endmodule

### dv/testbench.sv
// Self-checking stream testbench for the advertising data type finder top level.
module testbench
   import adt_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // The block's buffer limit; the predictor walks payloads against the same bound.
   localparam int BUFFER_LIMIT = 62;

   // The result register loads from the walker behind the input register. Words that give no
   // result may still be in the walker when the last result arrives, so a few spare
   // cycles are allowed before the wanted type is changed.
   localparam int SETTLE_CYCLES = 8;

   // Length of the long receiver hold-off that fills the block and stalls its input.
   localparam int STALL_CYCLES = 300;

   // Cycles without any handshake before the run is declared hung. The slowest correct
   // stretch is the long hold-off above plus a few random gaps.
   localparam int WATCHDOG_LIMIT = 3000;

   // One payload byte as the sender offers it.
   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              start;
   } adv_word_type;

   // One result word as the block should report it.
   typedef struct packed {
      status_type          status;
      logic [OFFSET_W-1:0] offset;
      logic [LENGTH_W-1:0] length;
   } finding_type;

   logic        clock;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata   = '0;    // [7:0] adv_byte
   logic        req_tuser   = 1'b0;  // [0] start_req
   logic        rsp_tvalid;
   logic        rsp_tready  = 1'b0;
   logic [15:0] rsp_tdata;           // [1:0] status, [7:2] value_offset, [15:8] value_length
   logic        csr_psel    = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite  = 1'b0;
   logic [2:0]  csr_paddr   = '0;
   logic [31:0] csr_pwdata  = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   adv_data_type_finder_top #(
      .BUFFER_LIMIT (BUFFER_LIMIT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // Payload words waiting for the driver, and results the block still owes us.
   adv_word_type payload_words[$];
   finding_type  expected_findings[$];

   int unsigned words_queued = 0;
   int unsigned error_count  = 0;

   // Percent of cycles in which each side idles; set by the stimulus sequence.
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;

   // The stimulus sequence bumps stall_orders to ask the receiver for one long hold-off.
   int unsigned stall_orders = 0;
   int unsigned stall_served = 0;
   int unsigned stall_left   = 0;

   // High for the cycle after a request word was taken, so the driver may move on.
   logic req_taken = 1'b0;

   // Our own copy of the walker: wanted type, phase, position, length and skip count.
   logic [BYTE_W-1:0]   model_wanted = WANTED_RESET;
   phase_type           walk_phase   = PH_DONE;
   logic [OFFSET_W-1:0] walk_pos     = '0;
   logic [LENGTH_W-1:0] walk_len     = '0;
   logic [LENGTH_W-1:0] walk_skip    = '0;

   int unsigned quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Every mismatch goes through here: one line, one count.
   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      error_count++;
   endtask

   // Advances the walker copy by one accepted byte and records the result it decides,
   // if any. A start byte with a bad wanted type is answered at once with invalid_type;
   // otherwise it restarts the walk, dropping any unfinished parse without a word.
   task automatic walk_payload_byte(input logic [BYTE_W-1:0] b, input logic start);
      finding_type f;
      bit          decided;
      decided        = 1'b0;
      f.status       = ST_NOT_FOUND;
      f.offset       = '0;
      f.length       = '0;
      if (start) begin
         if ((model_wanted < TYPE_MIN || model_wanted > TYPE_MAX) && model_wanted != TYPE_ANY) begin
            f.status = ST_INVALID;
            decided  = 1'b1;
         end else begin
            walk_phase = PH_LENGTH;
            walk_pos   = '0;
            walk_len   = '0;
            walk_skip  = '0;
         end
      end
      if (!decided) begin
         case (walk_phase)
            PH_LENGTH: begin
               // A zero length byte, or a length byte at the buffer limit, ends the search.
               if (b == '0 || int'(walk_pos) + 1 >= BUFFER_LIMIT) begin
                  decided = 1'b1;
               end else begin
                  walk_len   = b;
                  walk_pos   = walk_pos + 1'b1;
                  walk_phase = PH_TYPE;
               end
            end
            PH_TYPE: begin
               if (b == model_wanted) begin
                  f.status = ST_FOUND;
                  f.offset = walk_pos + 1'b1;
                  f.length = walk_len - 1'b1;
                  decided  = 1'b1;
               end else if (int'(walk_pos) + int'(walk_len) >= BUFFER_LIMIT) begin
                  // The next length byte would lie at or past the limit.
                  decided = 1'b1;
               end else begin
                  walk_skip  = walk_len - 1'b1;
                  walk_pos   = walk_pos + 1'b1;
                  walk_phase = (walk_skip != '0) ? PH_SKIP : PH_LENGTH;
               end
            end
            PH_SKIP: begin
               walk_skip = walk_skip - 1'b1;
               walk_pos  = walk_pos + 1'b1;
               if (walk_skip == '0) begin
                  walk_phase = PH_LENGTH;
               end
            end
            default: begin
               // Waiting for a start: the byte is ignored.
            end
         endcase
      end
      if (decided) begin
         walk_phase = PH_DONE;
         expected_findings.push_back(f);
      end
   endtask

   // Scoreboard: checks each result word against the oldest expectation, then predicts
   // from the request word taken at the same edge. Both happen on the rising edge, where
   // every block input has been stable since the previous falling edge.
   always @(posedge clock) begin : scoreboard
      finding_type f;
      if (reset) begin
         req_taken  <= 1'b0;
         walk_phase = PH_DONE;
         walk_pos   = '0;
         walk_len   = '0;
         walk_skip  = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_findings.size() == 0) begin
               report_mismatch($sformatf("result word %h with nothing expected", rsp_tdata));
            end else begin
               f = expected_findings.pop_front();
               if (rsp_tdata[1:0] != f.status) begin
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_tdata[1:0], f.status));
               end
               if (rsp_tdata[7:2] != f.offset) begin
                  report_mismatch($sformatf("value_offset %0d, expected %0d",
                                            rsp_tdata[7:2], f.offset));
               end
               if (rsp_tdata[15:8] != f.length) begin
                  report_mismatch($sformatf("value_length %0d, expected %0d",
                                            rsp_tdata[15:8], f.length));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            walk_payload_byte(req_tdata, req_tuser);
         end
         req_taken <= req_tvalid && req_tready;
      end
   end

   // Request driver: holds the offered word until it is taken, then either offers the
   // next pending word or idles, as the current idle rate decides.
   always @(negedge clock) begin : drive_req
      adv_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (payload_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            w = payload_words.pop_front();
            req_tdata  <= w.data;
            req_tuser  <= w.start;
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Result receiver: random back-pressure, plus the long hold-off when one is ordered.
   always @(negedge clock) begin : drive_rsp
      if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_served != stall_orders) begin
         stall_served <= stall_served + 1;
         stall_left   <= STALL_CYCLES;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: any handshake on any port counts as progress.
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("testbench: errors");
            $finish;
         end
      end
   end

   task automatic queue_word(input int b, input bit start);
      adv_word_type w;
      w.data  = b[7:0];
      w.start = start;
      payload_words.push_back(w);
      words_queued++;
   endtask

   // Builds one random payload. Most are well-formed chains of structures in which the
   // wanted type sits at a random structure, sometimes beyond the buffer limit so that the
   // walk runs out. Some are cut short, some hold a zero length byte, and a few are
   // stray bytes without a start or a lone start byte.
   task automatic queue_payload();
      int          pos;
      int          len;
      int          n;
      int          hit_at;
      int          cut;
      int          k;
      int unsigned kind;
      kind = $urandom_range(99);
      if (kind < 6) begin
         queue_word($urandom_range(255), 1'b0);
         return;
      end
      if (kind < 10) begin
         queue_word($urandom_range(255), 1'b1);
         return;
      end
      hit_at = ($urandom_range(3) == 0) ? $urandom_range(20) : $urandom_range(4);
      cut    = ($urandom_range(9) == 0) ? $urandom_range(1, 20) : 1000;
      pos    = 0;
      n      = 0;
      while (pos < 70 && pos < cut) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(255) : $urandom_range(1, 8);
         if ($urandom_range(29) == 0) begin
            len = 0;
         end
         queue_word(len, pos == 0);
         pos++;
         if (len == 0 || pos >= cut) begin
            break;
         end
         if (n == hit_at) begin
            // Matching type byte, then up to two bytes the block should ignore.
            queue_word(model_wanted, 1'b0);
            repeat ($urandom_range(2)) queue_word($urandom_range(255), 1'b0);
            break;
         end
         queue_word($urandom_range(255), 1'b0);
         pos++;
         k = (len - 1 < 70 - pos) ? len - 1 : 70 - pos;
         if (k < 0) begin
            k = 0;
         end
         repeat (k) begin
            queue_word($urandom_range(255), 1'b0);
            pos++;
         end
         n++;
      end
   endtask

   // Waits until every queued word is taken and every expected result has arrived,
   // then lets the walker settle.
   task automatic wait_idle();
      while (payload_words.size() != 0 || req_tvalid || expected_findings.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Writes the wanted type register; the bits above the register are random.
   task automatic write_wanted_type(input logic [BYTE_W-1:0] value);
      logic [31:0] word;
      word      = $urandom;
      word[7:0] = value;
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {CSR_WANTED_IDX, 2'b00};
      csr_pwdata  <= word;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      model_wanted = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Stimulus sequence: directed payloads at the reset wanted type, then random payloads
   // under a series of wanted types, moving through the three idling patterns.
   initial begin : stimulus
      int unsigned      target;
      logic [BYTE_W-1:0] setting;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 8;
      recv_idle_pct = 62;

      // A stray byte after reset is ignored.
      queue_word(8'h05, 1'b0);
      // Zero length byte right at the start.
      queue_word(8'h00, 1'b1);
      // Match in the first structure; the trailing byte is ignored.
      queue_word(8'h02, 1'b1);
      queue_word(8'h09, 1'b0);
      queue_word(8'hAA, 1'b0);
      // A start in the middle of a parse drops it and begins afresh.
      queue_word(8'h03, 1'b1);
      queue_word(8'h01, 1'b0);
      queue_word(8'h05, 1'b1);
      queue_word(8'h09, 1'b0);
      // Skip one structure, then match an empty value.
      queue_word(8'h02, 1'b1);
      queue_word(8'h01, 1'b0);
      queue_word(8'hFF, 1'b0);
      queue_word(8'h01, 1'b0);
      queue_word(8'h09, 1'b0);
      // Largest length that does not match runs past the buffer limit.
      queue_word(8'hFF, 1'b1);
      queue_word(8'h01, 1'b0);
      // Type-only structure, then a zero length byte later in the payload.
      queue_word(8'h01, 1'b1);
      queue_word(8'h07, 1'b0);
      queue_word(8'h00, 1'b0);
      // Match with the largest value length.
      queue_word(8'hFF, 1'b1);
      queue_word(8'h09, 1'b0);
      wait_idle();

      for (int i = 0; i < 9; i++) begin
         case (i)
            0:       setting = TYPE_ANY;
            1:       setting = TYPE_MIN;
            2:       setting = TYPE_MAX;
            3:       setting = 8'h00;
            4:       setting = TYPE_MAX + 1'b1;
            5:       setting = BYTE_W'($urandom_range(TYPE_MIN, TYPE_MAX));
            6:       setting = 8'hFE;
            7:       setting = BYTE_W'($urandom_range(255));
            default: setting = WANTED_RESET;
         endcase
         if (i < 3) begin
            send_idle_pct = 8;
            recv_idle_pct = 62;
         end else if (i < 6) begin
            send_idle_pct = 62;
            recv_idle_pct = 8;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         write_wanted_type(setting);

         if (i == 8) begin
            // Long receiver hold-off while the sender keeps offering start bytes with a
            // zero length, each of which decides a result, so the block backs up.
            stall_orders++;
            repeat (40) queue_word(8'h00, 1'b1);
            wait_idle();
         end

         // An invalid wanted type answers every start at once, so fewer words do.
         target = words_queued +
                  (((setting < TYPE_MIN || setting > TYPE_MAX) && setting != TYPE_ANY) ? 25 : 80);
         while (words_queued < target) begin
            queue_payload();
         end
         wait_idle();
      end

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

endmodule
